[design/c_string_escape_decoder_defines.svh]
// assertion macros for the c string escape decoder
`ifndef C_STRING_ESCAPE_DECODER_DEFINES_SVH
`define C_STRING_ESCAPE_DECODER_DEFINES_SVH
`ifndef SYNTHESIS
`define CESD_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cesd same-cycle check failed");
`define CESD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cesd next-cycle check failed");
`else
`define CESD_ASSERT_IMPL(label, ante, cons)
`define CESD_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[design/cesd_pkg.sv]
// shared types and constants of the c string escape decoder
`timescale 1ns / 1ps

package cesd_pkg;

    localparam int RES_FIFO_DEPTH = 4;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_DASH   = 8'h2d;
    localparam logic [7:0] CH_USCORE = 8'h5f;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_DEL    = 8'h7f;

    typedef enum logic [1:0] {
        MODE_ESCAPED   = 2'd0,
        MODE_RAW       = 2'd1,
        MODE_IDENT_REQ = 2'd2,
        MODE_IDENT_OPT = 2'd3
    } smode_t;

    typedef enum logic [2:0] {
        DM_PLAIN     = 3'd0,
        DM_BACKSLASH = 3'd1,
        DM_HEX_START = 3'd2,
        DM_HEX       = 3'd3,
        DM_OCTAL     = 3'd4
    } dmode_t;

    typedef struct packed {
        dmode_t     dmode;
        logic [7:0] accum;
        logic       seen;
    } state_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       is_end;
        logic       ctrl_warning;
        logic       unterminated;
        logic       empty_error;
        logic       last;
    } result_t;

    typedef struct packed {
        result_t    r0;
        result_t    r1;
        logic [1:0] n;
    } step_t;

endpackage

[design/c_string_escape_decoder.sv]
// top level of the c string escape decoder
`timescale 1ns / 1ps
`include "c_string_escape_decoder_defines.svh"

// usage
// - input channel in_valid/in_ready/in_byte carries one raw body byte per transfer
// - output channel out_valid/out_ready carries one result item per transfer:
//   out_char, is_end, ctrl_warning, unterminated, empty_error, last
// - each input byte yields zero, one or two result items; last marks the final one
// - string_mode is written through the apb port at address 0; a write also clears
//   the escape state; the user must write only while the block is idle, the block does not check
// - a result is registered in the result queue at its input transfer and shows on out_valid
// - throughput: one input byte per cycle while in_ready is high; the decoder state is a small
//   register updated from each byte (mode, shift-add escape accumulator)
// - the result queue holds DEPTH items; input is taken while two slots are free,
//   so a byte is taken while earlier results still wait on the output
// - output stall: the queue fills and in_ready drops; nothing is lost
// - reset: queue empty, string_mode escaped, decoder in plain state
module c_string_escape_decoder #(
    parameter int DEPTH = cesd_pkg::RES_FIFO_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input bytes
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    // result items
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_char,
    output logic        is_end,
    output logic        ctrl_warning,
    output logic        unterminated,
    output logic        empty_error,
    output logic        last
);

    cesd_pkg::smode_t  mode_reg, mode_next;
    cesd_pkg::state_t  state_reg, state_next, dec_nxt;
    cesd_pkg::step_t   step;
    cesd_pkg::result_t head;
    logic              cfg_wr;
    logic              in_fire;
    logic              room2;
    logic [1:0]        wr_cnt;
    logic [$clog2(DEPTH+1)-1:0] fifo_count;

    // single register; every address maps onto string_mode
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = {30'd0, mode_reg};

    assign in_ready = room2;
    assign in_fire  = in_valid && in_ready;

    cesd_decode u_decode (
        .string_mode (mode_reg),
        .cur         (state_reg),
        .in_byte     (in_byte),
        .nxt         (dec_nxt),
        .step        (step)
    );

    // a configuration write wins over a byte's state update in the same cycle
    always_comb
    begin
        mode_next  = mode_reg;
        state_next = state_reg;
        if (cfg_wr)
        begin
            mode_next  = cesd_pkg::smode_t'(pwdata[1:0]);
            state_next = '0;
        end
        else if (in_fire)
        begin
            state_next = dec_nxt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= cesd_pkg::MODE_ESCAPED;
            state_reg <= '0;
        end
        else
        begin
            mode_reg  <= mode_next;
            state_reg <= state_next;
        end
    end

    assign wr_cnt = in_fire ? step.n : 2'd0;

    // result register stage: queue of finished items
    cesd_result_fifo #(
        .DEPTH (DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_cnt   (wr_cnt),
        .wr_data0 (step.r0),
        .wr_data1 (step.r1),
        .rd_en    (out_ready),
        .rd_data  (head),
        .rd_valid (out_valid),
        .room2    (room2),
        .count    (fifo_count)
    );

    assign out_char     = head.out_char;
    assign is_end       = head.is_end;
    assign ctrl_warning = head.ctrl_warning;
    assign unterminated = head.unterminated;
    assign empty_error  = head.empty_error;
    assign last         = head.last;

    // queue never holds more than its depth
    `CESD_ASSERT_IMPL(a_count_bound, 1'b1, fifo_count <= DEPTH)
    // an end item at the front of a byte's results is its only result
    `CESD_ASSERT_IMPL(a_end_alone, in_fire && step.r0.is_end, step.n == 2'd1)
    // a register write leaves the decoder in clean plain state
    `CESD_ASSERT_NEXT(a_cfg_clear, cfg_wr, state_reg == '0)

endmodule

[design/cesd_decode.sv]
// per-byte decode: next decoder state and up to two result items
`timescale 1ns / 1ps

module cesd_decode (
    input  cesd_pkg::smode_t string_mode,
    input  cesd_pkg::state_t cur,
    input  logic [7:0]       in_byte,
    output cesd_pkg::state_t nxt,
    output cesd_pkg::step_t  step
);

    function automatic logic [7:0] esc_char(input logic [7:0] b);
        logic [7:0] c;
        begin
            case (b)
                8'h61:   c = 8'd7;
                8'h62:   c = 8'd8;
                8'h66:   c = 8'd12;
                8'h6e:   c = 8'd10;
                8'h72:   c = 8'd13;
                8'h74:   c = 8'd9;
                8'h76:   c = 8'd11;
                default: c = b;
            endcase
            return c;
        end
    endfunction

    logic       is_term;
    logic       is_quote;
    logic       is_ctrl;
    logic       is_bs;
    logic       is_dig;
    logic       is_lc_hex;
    logic       is_uc_hex;
    logic       hex_ok;
    logic [3:0] hex_val;
    logic       oct_ok;
    logic       is_ident;

    assign is_term   = (in_byte == cesd_pkg::CH_NUL) || (in_byte == cesd_pkg::CH_LF)
                    || (in_byte == cesd_pkg::CH_CR);
    assign is_quote  = (in_byte == cesd_pkg::CH_QUOTE);
    assign is_ctrl   = (in_byte < 8'h20) || (in_byte == cesd_pkg::CH_DEL);
    assign is_bs     = (in_byte == cesd_pkg::CH_BSLASH);
    assign is_dig    = (in_byte >= 8'h30) && (in_byte <= 8'h39);
    assign is_lc_hex = (in_byte >= 8'h61) && (in_byte <= 8'h66);
    assign is_uc_hex = (in_byte >= 8'h41) && (in_byte <= 8'h46);
    assign hex_ok    = is_dig || is_lc_hex || is_uc_hex;
    // letters a-f and A-F share the low nibble pattern 1..6
    assign hex_val   = is_dig ? in_byte[3:0] : (in_byte[3:0] + 4'd9);
    assign oct_ok    = (in_byte[7:3] == 5'b00110);
    assign is_ident  = is_dig || ((in_byte >= 8'h61) && (in_byte <= 8'h7a))
                    || ((in_byte >= 8'h41) && (in_byte <= 8'h5a))
                    || (in_byte == cesd_pkg::CH_USCORE) || (in_byte == cesd_pkg::CH_DASH);

    // pending escape flushed by this byte, and whether the byte then runs as plain text
    logic              pre_valid;
    logic [7:0]        pre_char;
    logic              run_plain;
    logic              p_valid;
    logic              p_finish;
    logic              p_bs;
    cesd_pkg::result_t p_res;

    always_comb
    begin
        pre_valid = 1'b0;
        pre_char  = cur.accum;
        run_plain = 1'b0;
        if (string_mode == cesd_pkg::MODE_ESCAPED)
        begin
            case (cur.dmode)
                cesd_pkg::DM_BACKSLASH: run_plain = 1'b0;
                cesd_pkg::DM_HEX_START:
                begin
                    pre_valid = !hex_ok;
                    pre_char  = cesd_pkg::CH_X;
                    run_plain = !hex_ok;
                end
                cesd_pkg::DM_HEX:
                begin
                    pre_valid = !hex_ok;
                    run_plain = !hex_ok;
                end
                cesd_pkg::DM_OCTAL:
                begin
                    pre_valid = !oct_ok;
                    run_plain = !oct_ok;
                end
                default: run_plain = 1'b1;
            endcase
        end
    end

    // plain-state handling of an escaped-mode byte
    always_comb
    begin
        p_res          = '0;
        p_valid        = run_plain && !is_bs;
        p_finish       = run_plain && (is_quote || is_term);
        p_bs           = run_plain && is_bs;
        p_res.out_char = in_byte;
        if (is_quote || is_term)
        begin
            p_res.out_char     = 8'd0;
            p_res.is_end       = 1'b1;
            p_res.unterminated = !is_quote;
        end
        else
        begin
            p_res.ctrl_warning = is_ctrl;
        end
    end

    // next decoder state
    always_comb
    begin
        nxt = cur;
        case (string_mode)
            cesd_pkg::MODE_RAW:
            begin
                if (is_term)
                    nxt = '0;
                else
                    nxt.seen = 1'b1;
            end
            cesd_pkg::MODE_IDENT_REQ, cesd_pkg::MODE_IDENT_OPT:
            begin
                if (is_ident)
                    nxt.seen = 1'b1;
                else
                    nxt = '0;
            end
            default:
            begin
                case (cur.dmode)
                    cesd_pkg::DM_BACKSLASH:
                    begin
                        nxt.dmode = cesd_pkg::DM_PLAIN;
                        if (in_byte == cesd_pkg::CH_NUL)
                            nxt = '0;
                        else if (in_byte == cesd_pkg::CH_X)
                            nxt.dmode = cesd_pkg::DM_HEX_START;
                        else if (oct_ok)
                        begin
                            nxt.dmode = cesd_pkg::DM_OCTAL;
                            nxt.accum = {5'd0, in_byte[2:0]};
                        end
                        else
                            nxt.seen = 1'b1;
                    end
                    cesd_pkg::DM_HEX_START:
                    begin
                        if (hex_ok)
                        begin
                            nxt.dmode = cesd_pkg::DM_HEX;
                            nxt.accum = {4'd0, hex_val};
                        end
                    end
                    cesd_pkg::DM_HEX:
                    begin
                        if (hex_ok)
                            nxt.accum = {cur.accum[3:0], hex_val};
                        else
                            nxt.accum = 8'd0;
                    end
                    cesd_pkg::DM_OCTAL:
                    begin
                        if (oct_ok)
                            nxt.accum = {cur.accum[4:0], in_byte[2:0]};
                        else
                            nxt.accum = 8'd0;
                    end
                    default: nxt.dmode = cesd_pkg::DM_PLAIN;
                endcase
                if (run_plain)
                begin
                    nxt.dmode = p_bs ? cesd_pkg::DM_BACKSLASH : cesd_pkg::DM_PLAIN;
                    if (pre_valid || (p_valid && !p_finish))
                        nxt.seen = 1'b1;
                    if (p_finish)
                        nxt = '0;
                end
            end
        endcase
    end

    // result items
    always_comb
    begin
        step = '0;
        case (string_mode)
            cesd_pkg::MODE_RAW:
            begin
                step.n           = 2'd1;
                step.r0.out_char = is_term ? 8'd0 : in_byte;
                step.r0.is_end   = is_term;
            end
            cesd_pkg::MODE_IDENT_REQ, cesd_pkg::MODE_IDENT_OPT:
            begin
                step.n           = 2'd1;
                step.r0.out_char = is_ident ? in_byte : 8'd0;
                step.r0.is_end   = !is_ident;
                step.r0.empty_error = !is_ident && !cur.seen
                                   && (string_mode == cesd_pkg::MODE_IDENT_REQ);
            end
            default:
            begin
                if (cur.dmode == cesd_pkg::DM_BACKSLASH)
                begin
                    if (in_byte == cesd_pkg::CH_NUL)
                    begin
                        step.n               = 2'd1;
                        step.r0.is_end       = 1'b1;
                        step.r0.unterminated = 1'b1;
                    end
                    else if ((in_byte != cesd_pkg::CH_X) && !oct_ok)
                    begin
                        step.n           = 2'd1;
                        step.r0.out_char = esc_char(in_byte);
                    end
                end
                else if (pre_valid)
                begin
                    step.r0.out_char = pre_char;
                    step.r1          = p_res;
                    step.n           = p_valid ? 2'd2 : 2'd1;
                end
                else if (p_valid)
                begin
                    step.r0 = p_res;
                    step.n  = 2'd1;
                end
            end
        endcase
        step.r0.last = (step.n == 2'd1);
        step.r1.last = (step.n == 2'd2);
    end

endmodule

[design/cesd_result_fifo.sv]
// result queue taking up to two items per cycle and giving one
`timescale 1ns / 1ps

module cesd_result_fifo #(
    parameter int DEPTH = cesd_pkg::RES_FIFO_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [1:0]        wr_cnt,
    input  cesd_pkg::result_t wr_data0,
    input  cesd_pkg::result_t wr_data1,
    input  logic              rd_en,
    output cesd_pkg::result_t rd_data,
    output logic              rd_valid,
    output logic              room2,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    // depth must be a power of two of at least two so pointers wrap naturally; the block does not check this
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cesd_pkg::result_t mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             pop;

    assign pop         = rd_en && rd_valid;
    assign wr_ptr_next = wr_ptr_reg + PTR_W'(wr_cnt);
    assign rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
    assign cnt_next    = cnt_reg + CNT_W'(wr_cnt) - CNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_cnt != 2'd0)
            mem_reg[wr_ptr_reg] <= wr_data0;
        if (wr_cnt == 2'd2)
            mem_reg[wr_ptr_reg + PTR_W'(1)] <= wr_data1;
    end

    assign rd_data  = mem_reg[rd_ptr_reg];
    assign rd_valid = (cnt_reg != '0);
    assign room2    = (cnt_reg <= CNT_W'(DEPTH - 2));
    assign count    = cnt_reg;

endmodule
